// ----- rtl/ddwo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwo_pkg
// Shared types, constants and the quarter sine table generator for the
// differential drive wheel odometry block.
// ----------------------------------------------------------------------------
package ddwo_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_LIN    = 2'd1,
    REG_ANG    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DS,
    ST_TH,
    ST_LOOK,
    ST_X,
    ST_Y,
    ST_DONE
  } state_t;

  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = 64'sd5026995;
  localparam longint SIN_C9 = 64'sd172271;
  localparam longint Q30_ONE = 64'sd1073741824;

  // entry i of the quarter wave, Q1.30, evaluated at elaboration
  function automatic logic [30:0] quarter_sin_val(input int i, input int tb);
    longint u;
    longint u2;
    longint t;
    longint s;
    u  = longint'(i) <<< (30 - tb);
    u2 = (u * u) >>> 30;
    t  = SIN_C9;
    t  = SIN_C7 - ((u2 * t) >>> 30);
    t  = SIN_C5 - ((u2 * t) >>> 30);
    t  = SIN_C3 - ((u2 * t) >>> 30);
    t  = SIN_C1 - ((u2 * t) >>> 30);
    s  = (u * t) >>> 30;
    if (s < 0) s = 0;
    if (s > Q30_ONE) s = Q30_ONE;
    return s[30:0];
  endfunction

endpackage

// ----- rtl/diff_drive_wheel_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_odometry
// Planar pose tracking from cumulative left/right wheel encoder counts.
// ----------------------------------------------------------------------------
// A left count transaction is latched as it is accepted. A right count transaction
// (while enabled) runs one pose update: four products through one shared
// radix-16 digit-serial multiplier (distance, heading change, x and y
// increments), four sine/cosine reads of the registered quarter wave table
// and a final load of the output register. The input is taken again only
// once the update has loaded its result, so a right count is not accepted
// while the previous update is still running; a full output register holds
// the update in its last step. While an update runs or its result waits,
// no transaction is taken, left counts and clears included.
module diff_drive_wheel_odometry #(
  parameter int TRIG_TABLE_BITS = ddwo_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // tick_count
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // pos_x, pos_y, heading, quat_z, quat_w
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ddwo_pkg::*;

  localparam int TB        = TRIG_TABLE_BITS;
  localparam int IDX_W     = TB + 1;
  localparam int TAB_DEPTH = (1 << TB) + 1;
  localparam int HALF_STEP = 1 << (29 - TB);
  localparam logic [IDX_W-1:0] TAB_N = IDX_W'(TAB_DEPTH - 1);
  localparam logic [3:0] MUL_LAST = 4'd8;
  localparam logic [2:0] PH_LAST  = 3'd5;

  // configuration
  logic        enable;
  logic [31:0] lin_coef;
  logic [31:0] ang_coef;

  // odometry state
  logic [31:0] latest_left;
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic [31:0] pose_heading;

  logic [31:0] dl;
  logic [31:0] dr;
  logic [32:0] dsum;
  logic [32:0] ddiff;
  logic [31:0] ds;
  logic [31:0] cos_h;
  logic [31:0] sin_h;
  logic [31:0] quat_z;
  logic [31:0] quat_w;

  state_t state, state_next;
  logic [3:0] mcnt;
  logic [2:0] ph;

  // digit-serial multiplier
  logic signed [37:0] mh;
  logic [35:0]        ml;
  logic signed [32:0] ma;
  logic [35:0]        mb;
  logic signed [37:0] h_in;
  logic [35:0]        l_in;
  logic signed [4:0]  dig;
  logic signed [37:0] ma_x;
  logic signed [37:0] dig_x;
  logic signed [37:0] msum;
  logic [73:0]        pr;

  // control decode
  logic in_acc;
  logic start_upd;
  logic mul_run;
  logic mul_last;
  logic out_free;

  // table
  logic [30:0]      trig_tab [TAB_DEPTH];
  logic [IDX_W:0]   rd_addr;
  logic [30:0]      rom_q;
  logic             rom_neg;
  logic [31:0]      rom_val;

  // derived results
  logic [57:0] ds_full;
  logic [31:0] ds_sat;
  logic [44:0] pos_sum;
  logic [31:0] pos_sat;
  logic [31:0] ang_sel;

  for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
    assign trig_tab[gi] = quarter_sin_val(gi, TB);
  end

  function automatic logic [IDX_W:0] trig_addr(input logic [31:0] a);
    logic [30:0]      s;
    logic [IDX_W-1:0] idx;
    s   = {1'b0, a[29:0]} + 31'(HALF_STEP);
    idx = s[30:30-TB];
    if (idx > TAB_N) idx = TAB_N;
    if (a[30]) idx = TAB_N - idx;
    return {a[31], idx};
  endfunction

  assign in_acc    = s_tvalid && s_tready;
  assign start_upd = in_acc && (s_tuser == OP_RIGHT) && enable;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign pr        = {mh, ml};
  assign dl        = latest_left - prev_left;
  assign dr        = s_tdata - prev_right;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start_upd) state_next = ST_DS;
      ST_DS:   if (mul_last) state_next = ST_TH;
      ST_TH:   if (mul_last) state_next = ST_LOOK;
      ST_LOOK: if (ph == PH_LAST) state_next = ST_X;
      ST_X:    if (mul_last) state_next = ST_Y;
      ST_Y:    if (mul_last) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs and operand selection
  always_comb begin
    s_tready = 1'b0;
    mul_run  = 1'b0;
    ma       = '0;
    mb       = '0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DS: begin
        mul_run = 1'b1;
        ma      = dsum;
        mb      = {{4{lin_coef[31]}}, lin_coef};
      end
      ST_TH: begin
        mul_run = 1'b1;
        ma      = ddiff;
        mb      = {{4{ang_coef[31]}}, ang_coef};
      end
      ST_X: begin
        mul_run = 1'b1;
        ma      = {ds[31], ds};
        mb      = {{4{cos_h[31]}}, cos_h};
      end
      ST_Y: begin
        mul_run = 1'b1;
        ma      = {ds[31], ds};
        mb      = {{4{sin_h[31]}}, sin_h};
      end
      default: s_tready = 1'b0;
    endcase
  end

  assign mul_last = mul_run && (mcnt == MUL_LAST);

  always_comb begin
    h_in  = (mcnt == 4'd0) ? '0 : mh;
    l_in  = (mcnt == 4'd0) ? mb : ml;
    dig   = (mcnt == MUL_LAST) ? {l_in[3], l_in[3:0]} : {1'b0, l_in[3:0]};
    ma_x  = {{5{ma[32]}}, ma};
    dig_x = {{33{dig[4]}}, dig};
    msum  = h_in + ma_x * dig_x;
  end

  always_comb begin
    ds_full = pr[73:16];
    if ((&ds_full[57:31]) || !(|ds_full[57:31])) ds_sat = ds_full[31:0];
    else if (ds_full[57]) ds_sat = 32'h8000_0000;
    else ds_sat = 32'h7FFF_FFFF;
    pos_sum = (state == ST_Y) ? {{13{pose_x[31]}}, pose_x} : {{13{pose_y[31]}}, pose_y};
    pos_sum = pos_sum + {pr[73], pr[73:30]};
    if ((&pos_sum[44:31]) || !(|pos_sum[44:31])) pos_sat = pos_sum[31:0];
    else if (pos_sum[44]) pos_sat = 32'h8000_0000;
    else pos_sat = 32'h7FFF_FFFF;
  end

  always_comb begin
    case (ph)
      3'd1:    ang_sel = pose_heading + 32'h4000_0000;
      3'd2:    ang_sel = pose_heading;
      3'd3:    ang_sel = {1'b0, pose_heading[31:1]};
      default: ang_sel = {1'b0, pose_heading[31:1]} + 32'h4000_0000;
    endcase
    rd_addr = trig_addr(ang_sel);
    rom_val = rom_neg ? -{1'b0, rom_q} : {1'b0, rom_q};
  end

  always_ff @(posedge clk) begin
    rom_q   <= trig_tab[rd_addr[IDX_W-1:0]];
    rom_neg <= rd_addr[IDX_W];
    if (mul_run) begin
      mh <= msum >>> 4;
      ml <= {msum[3:0], l_in[35:4]};
    end
    if (start_upd) begin
      dsum  <= {dl[31], dl} + {dr[31], dr};
      ddiff <= {dr[31], dr} - {dl[31], dl};
    end
    if (state == ST_TH && mcnt == 4'd0) ds <= ds_sat;
    if (state == ST_LOOK) begin
      case (ph)
        3'd2:    cos_h  <= rom_val;
        3'd3:    sin_h  <= rom_val;
        3'd4:    quat_z <= rom_val;
        3'd5:    quat_w <= rom_val;
        default: ;
      endcase
    end
    if (state == ST_DONE && out_free) m_tdata <= {quat_w, quat_z, pose_heading, pos_sat, pose_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mcnt         <= '0;
      ph           <= '0;
      m_tvalid     <= 1'b0;
      enable       <= 1'b1;
      lin_coef     <= '0;
      ang_coef     <= '0;
      latest_left  <= '0;
      prev_left    <= '0;
      prev_right   <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      state <= state_next;
      if (mul_run) mcnt <= mul_last ? 4'd0 : mcnt + 4'd1;
      if (state == ST_LOOK) ph <= (ph == PH_LAST) ? 3'd0 : ph + 3'd1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE: enable   <= cfg_data[0];
          REG_LIN:    lin_coef <= cfg_data;
          REG_ANG:    ang_coef <= cfg_data;
          default:    ;
        endcase
      end
      if (in_acc) begin
        case (s_tuser)
          OP_LEFT: latest_left <= s_tdata;
          OP_RIGHT: begin
            if (enable) begin
              prev_left  <= latest_left;
              prev_right <= s_tdata;
            end
          end
          OP_CLEAR: begin
            if (s_tdata != 32'd0) begin
              pose_x       <= '0;
              pose_y       <= '0;
              pose_heading <= '0;
              prev_left    <= '0;
              prev_right   <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_LOOK && ph == 3'd0) pose_heading <= pose_heading + pr[63:32];
      if (state == ST_Y && mcnt == 4'd0) pose_x <= pos_sat;
      if (state == ST_DONE && out_free) begin
        pose_y   <= pos_sat;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    start_upd |=> state == ST_DS)
    else $error("update did not start");
  a_mul_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == ST_X && $past(state) == ST_LOOK) |-> mcnt == 4'd0)
    else $error("multiplier count not clear");
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[159:128]) <= 32'sd1073741824 &&
                  $signed(m_tdata[159:128]) >= -32'sd1073741824))
    else $error("quat_w out of range");
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_acc)
    else $error("input taken during update");

endmodule

// ----- dv/tb_diff_drive_wheel_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_wheel_odometry
// Self-checking bench for the wheel odometry block. A behavioral pose tracker
// predicts every update from the encoder count transactions; the monitor
// compares each output transaction field by field against the oldest
// predicted pose. Directed cases, random register writes and random traffic with
// random stalls on both sides, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_diff_drive_wheel_odometry;
  import ddwo_pkg::*;

  localparam int TB = TRIG_TABLE_BITS_DEF;
  localparam int QN = 1 << TB;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] quat_w;
    logic [31:0] quat_z;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [159:0] m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  diff_drive_wheel_odometry u_dut (.*);

  always #4 clk = ~clk;

  longint qsin [0:QN];
  logic        en_r;
  logic [31:0] lin_r, ang_r;
  logic [31:0] left_latest, left_prev, right_prev, hd;
  logic signed [31:0] px, py;
  pose_t pose_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_off = 0;
  bit  stall_en = 1;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sin_lookup(logic [31:0] a);
    logic [1:0]  quad;
    logic [31:0] idx;
    longint      v;
    quad = a[31:30];
    idx = ({2'b0, a[29:0]} + (32'd1 << (29 - TB))) >> (30 - TB);
    if (idx > QN) idx = QN;
    if (quad[0]) idx = QN - idx;
    v = qsin[idx];
    return quad[1] ? -v : v;
  endfunction

  task automatic build_sine;
    longint u, u2, t, s;
    for (int i = 0; i <= QN; i++) begin
      u  = longint'(i) <<< (30 - TB);
      u2 = (u * u) >>> 30;
      t  = 172271;
      t  = 5026995 - ((u2 * t) >>> 30);
      t  = 85569306 - ((u2 * t) >>> 30);
      t  = 693598668 - ((u2 * t) >>> 30);
      t  = 1686629713 - ((u2 * t) >>> 30);
      s  = (u * t) >>> 30;
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      qsin[i] = s;
    end
  endtask

  // pose tracker: advances the predicted pose for one input transaction
  task automatic track_pose(op_t op, logic [31:0] tick);
    longint dl, dr, lin, p1, p2, ds;
    logic [63:0] pa;
    logic [31:0] half;
    pose_t r;
    case (op)
      OP_LEFT: left_latest = tick;
      OP_CLEAR: if (tick != 0) begin
        px = 0; py = 0; hd = 0; left_prev = 0; right_prev = 0;
      end
      OP_RIGHT: if (en_r) begin
        dl  = longint'($signed(left_latest - left_prev));
        dr  = longint'($signed(tick - right_prev));
        lin = longint'($signed(lin_r));
        p1  = lin * dl;
        p2  = lin * dr;
        ds  = fshift(p1, 16) + fshift(p2, 16) + (((p1 & 64'hFFFF) + (p2 & 64'hFFFF)) >>> 16);
        ds  = sat(ds);
        pa  = 64'(longint'($signed(ang_r))) * 64'(dr - dl);
        hd  = hd + pa[63:32];
        px  = 32'(sat(longint'(px) + fshift(ds * sin_lookup(hd + 32'h40000000), 30)));
        py  = 32'(sat(longint'(py) + fshift(ds * sin_lookup(hd), 30)));
        left_prev  = left_latest;
        right_prev = tick;
        half = hd >> 1;
        r.pos_x = px; r.pos_y = py; r.heading = hd;
        r.quat_z = 32'(sin_lookup(half));
        r.quat_w = 32'(sin_lookup(half + 32'h40000000));
        pose_q = {pose_q, r};
      end
      default: ;
    endcase
  endtask

  // valid stays high into the next transaction when no idle cycles follow
  task automatic send_count(op_t op, logic [31:0] tick);
    int gap;
    gap = stall_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    track_pose(op, tick);
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= tick;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained;
    s_tvalid <= 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    wait_drained();
    case (idx)
      REG_ENABLE: en_r = val[0];
      REG_LIN:    lin_r = val;
      REG_ANG:    ang_r = val;
      default: ;
    endcase
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // output side stalls
  always begin
    int w;
    w = stall_en ? $urandom_range(0, 8) : 0;
    if (w > 0 || hold_off) begin
      m_tready <= 0;
      repeat (w) @(posedge clk);
      while (hold_off) @(posedge clk);
    end
    m_tready <= 1;
    do @(posedge clk); while (!m_tvalid);
  end

  always @(posedge clk) begin
    pose_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pose_q.size() == 0) begin
        $display("%t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x)
          $display("%t pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
        if (got.pos_y !== want.pos_y)
          $display("%t pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
        if (got.heading !== want.heading)
          $display("%t heading exp %h got %h", $time, want.heading, got.heading);
        if (got.quat_z !== want.quat_z)
          $display("%t quat_z exp %h got %h", $time, want.quat_z, got.quat_z);
        if (got.quat_w !== want.quat_w)
          $display("%t quat_w exp %h got %h", $time, want.quat_w, got.quat_w);
        if (got !== want) errors++;
      end
    end
  end

  function automatic logic [31:0] rnd_coef;
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h00FFFFFF);
      3: return -$urandom_range(0, 32'h00FFFFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    write_reg(REG_LIN, 32'h01000000);
    write_reg(REG_ANG, 32'h00400000);
    send_count(OP_RIGHT, 32'd0);
    send_count(OP_LEFT, 32'd100);
    send_count(OP_RIGHT, 32'd300);
    send_count(OP_LEFT, 32'h7FFFFFFF);
    send_count(OP_RIGHT, 32'h80000000);
    send_count(OP_LEFT, 32'hFFFFFFFF);
    send_count(OP_RIGHT, 32'hFFFFFFFF);
    send_count(OP_NONE, 32'h12345678);
    send_count(OP_RIGHT, 32'd5);
    send_count(OP_CLEAR, 32'd0);
    send_count(OP_RIGHT, 32'd9);
    send_count(OP_CLEAR, 32'hFFFFFFFF);
    send_count(OP_RIGHT, 32'd40);
    write_reg(REG_ENABLE, 32'd0);
    send_count(OP_LEFT, 32'd77);
    send_count(OP_RIGHT, 32'd999);
    write_reg(REG_ENABLE, 32'd1);
    send_count(OP_RIGHT, 32'd1000);
    write_reg(REG_NONE, 32'hFFFFFFFF);
    write_reg(REG_LIN, 32'h7FFFFFFF);
    write_reg(REG_ANG, 32'h80000000);
    send_count(OP_LEFT, 32'h80000000);
    send_count(OP_RIGHT, 32'h7FFFFFFF);
    send_count(OP_RIGHT, 32'h00000000);
  endtask

  task automatic test_backpressure;
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++)
        send_count(i % 2 ? OP_RIGHT : OP_LEFT, $urandom);
    join
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [31:0] l, r;
    op_t op;
    l = $urandom; r = $urandom;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        write_reg(REG_LIN, rnd_coef());
        write_reg(REG_ANG, rnd_coef());
        write_reg(REG_ENABLE, 32'($urandom_range(0, 3) != 0));
        stall_en = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 19))
        0: send_count(OP_CLEAR, $urandom_range(0, 1) ? $urandom : 32'd0);
        1: send_count(OP_NONE, $urandom);
        2: send_count(OP_RIGHT, $urandom);
        3: send_count(OP_LEFT, $urandom);
        default: begin
          op = $urandom_range(0, 1) ? OP_LEFT : OP_RIGHT;
          if (op == OP_LEFT) begin
            l = l + 32'($signed($urandom_range(0, 4000)) - 2000);
            send_count(op, l);
          end else begin
            r = r + 32'($signed($urandom_range(0, 4000)) - 2000);
            send_count(op, r);
          end
        end
      endcase
    end
    stall_en = 1;
    write_reg(REG_ENABLE, 32'd1);
  endtask

  initial begin
    build_sine();
    en_r = 1; lin_r = 0; ang_r = 0;
    left_latest = 0; left_prev = 0; right_prev = 0; hd = 0; px = 0; py = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(850);
    wait_drained();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
